// File: hw/rtl/rbsf_pkg.sv
// Package for the record byte-stuffing framer.
// Types and constants shared by the front, queue, back and top level.
// No dependencies.
package rbsf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0] EscByte = 8'h5C;
  localparam logic [ByteW-1:0] DelimByte = 8'h00;

  // Output slots of one item, emitted lowest bit first
  localparam int unsigned SlotW = 6;
  localparam int unsigned SlotPre0 = 0;
  localparam int unsigned SlotPre1 = 1;
  localparam int unsigned SlotEsc = 2;
  localparam int unsigned SlotData = 3;
  localparam int unsigned SlotDlm0 = 4;
  localparam int unsigned SlotDlm1 = 5;

  typedef enum logic [1:0] {
    PH_ID      = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             pre;
    logic             esc;
    logic             dlm;
  } desc_t;

endpackage

// File: hw/rtl/record_byte_stuffing_framer_top.sv
// Record byte-stuffing framer, top level.
// Input stream s_axis carries raw record bytes (id, length L, L+1 payload bytes).
// Output stream m_axis carries the escaped, delimited bytes; tlast marks the
// final output byte produced by each input item.
// Each input byte yields 1 to 4 output bytes: bytes 0x00 and 0x5C get a 0x5C
// escape in front, two 0x00 delimiters follow a record's last payload byte,
// and the first item after reset is preceded by two 0x00 bytes.
// Path: an accepted item passes the queue and then the output register before
// its first output byte shows, when the output side is free.
// Throughput: the back end emits one output byte per cycle while m_axis_tready
// is high; a four-entry queue lets the input side take a byte every cycle until
// the queue fills.
// Reset (rst_ni low, asynchronous) returns to expecting a record id, re-arms the
// leading delimiter pair and empties the queue and the output register.
// When m_axis_tready is low the output byte holds, the back end stops, and
// s_axis_tready drops once the queue is full.
// Depends on rbsf_pkg, rbsf_front, rbsf_queue, rbsf_back.
module record_byte_stuffing_framer_top
  import rbsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_of_run
);

  logic  push, full, pop, head_valid;
  desc_t push_desc, head_desc;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  rbsf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (s_axis_tdata),
    .desc_o (push_desc)
  );

  rbsf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc)
  );

  rbsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// File: hw/rtl/rbsf_front.sv
// Front end: accepts input bytes, tracks record phase and classifies each item.
// Depends on rbsf_pkg.
module rbsf_front
  import rbsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ByteW-1:0] data_i,
  output desc_t            desc_o
);

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   left_q, left_d;
  logic                pre_sent_q, pre_sent_d;
  logic                rec_end;

  assign rec_end = (phase_q == PH_PAYLOAD) && (left_q <= CountW'(1));

  // next state
  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    pre_sent_d = pre_sent_q;
    if (push_i) begin
      pre_sent_d = 1'b1;
      unique case (phase_q)
        PH_LEN: begin
          left_d  = CountW'(data_i) + CountW'(1);
          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (rec_end) begin
            left_d  = '0;
            phase_d = PH_ID;
          end else begin
            left_d = left_q - CountW'(1);
          end
        end
        default: phase_d = PH_LEN;
      endcase
    end
  end

  // outputs
  always_comb begin
    desc_o.data = data_i;
    desc_o.pre  = !pre_sent_q;
    desc_o.esc  = (data_i == DelimByte) || (data_i == EscByte);
    desc_o.dlm  = rec_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ID;
      left_q     <= '0;
      pre_sent_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      left_q     <= left_d;
      pre_sent_q <= pre_sent_d;
    end
  end

endmodule

// File: hw/rtl/rbsf_queue.sv
// Short queue of classified items between front and back.
// Depends on rbsf_pkg.
module rbsf_queue
  import rbsf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output desc_t head_desc_o
);

  desc_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/rbsf_back.sv
// Back end: expands each classified item into its output bytes, one per cycle
// unless the output stalls, into a registered output stage. Depends on rbsf_pkg.
module rbsf_back
  import rbsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  desc_t            head_desc_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o
);

  logic [SlotW-1:0] slots_q, slots_d;
  logic [ByteW-1:0] data_q;
  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;

  logic             adv;
  logic             take_new;
  logic [SlotW-1:0] cur_slots, new_slots, low_bit;
  logic [ByteW-1:0] cur_data;

  assign adv = !valid_q || out_ready_i;

  always_comb begin
    new_slots           = '0;
    new_slots[SlotPre0] = head_desc_i.pre;
    new_slots[SlotPre1] = head_desc_i.pre;
    new_slots[SlotEsc]  = head_desc_i.esc;
    new_slots[SlotData] = 1'b1;
    new_slots[SlotDlm0] = head_desc_i.dlm;
    new_slots[SlotDlm1] = head_desc_i.dlm;
  end

  // when the current item runs dry and the output can advance, the next one starts in the same cycle
  assign take_new  = adv && (slots_q == '0) && head_valid_i;
  assign pop_o     = take_new;
  assign cur_slots = (slots_q != '0) ? slots_q : (head_valid_i ? new_slots : '0);
  assign cur_data  = (slots_q != '0) ? data_q : head_desc_i.data;
  assign low_bit   = cur_slots & (~cur_slots + SlotW'(1));

  always_comb begin
    slots_d = slots_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (adv) begin
      slots_d = cur_slots & ~low_bit;
      valid_d = (cur_slots != '0);
      last_d  = ((cur_slots & ~low_bit) == '0);
      priority if (low_bit[SlotEsc]) begin
        byte_d = EscByte;
      end else if (low_bit[SlotData]) begin
        byte_d = cur_data;
      end else begin
        byte_d = DelimByte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_new) begin
      data_q <= head_desc_i.data;
    end
    byte_q <= byte_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
      valid_q <= 1'b0;
    end else begin
      slots_q <= slots_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// File: hw/rtl/rbsf_checker.sv
// Port-level checker for the record byte-stuffing framer, bound to the top level.
// Depends on record_byte_stuffing_framer_top ports only.
module rbsf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // an accepted item is followed by a valid output byte once it has passed the queue and the output register
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
    else $error("accepted item did not reach output");

  // an idle output implies the queue has room
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output item changed while stalled");

endmodule

bind record_byte_stuffing_framer_top rbsf_checker u_rbsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
